/* rtl/atrs_pkg.sv */
// Shared types, constants and helpers for the affine TRS matrix builder.
// Depends on nothing. All other files import this package.
`timescale 1ns / 1ps
package atrs_pkg;

  localparam int CORDIC_STAGES = 16;  // range 8 to 24
  localparam int AtanLen = 24;

  // CORDIC datapath widths: x/y in Q2.30 with headroom, angle with headroom
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // Latency in cycles from an accepted start to the result strobe edge
  localparam int LATENCY = CORDIC_STAGES + 6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic        [15:0] angle;
  } atrs_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } atrs_out_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic signed [ZW-1:0] atan_lut(input int idx);
    logic signed [ZW-1:0] v;
    begin
      case (idx)
        0:       v = 34'sd536870912;
        1:       v = 34'sd316933406;
        2:       v = 34'sd167458907;
        3:       v = 34'sd85004756;
        4:       v = 34'sd42667331;
        5:       v = 34'sd21354465;
        6:       v = 34'sd10679838;
        7:       v = 34'sd5340245;
        8:       v = 34'sd2670163;
        9:       v = 34'sd1335087;
        10:      v = 34'sd667544;
        11:      v = 34'sd333772;
        12:      v = 34'sd166886;
        13:      v = 34'sd83443;
        14:      v = 34'sd41722;
        15:      v = 34'sd20861;
        16:      v = 34'sd10430;
        17:      v = 34'sd5215;
        18:      v = 34'sd2608;
        19:      v = 34'sd1304;
        20:      v = 34'sd652;
        21:      v = 34'sd326;
        22:      v = 34'sd163;
        23:      v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Clamp to the int32 range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    begin
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

/* rtl/atrs_cordic.sv */
// Pipelined rotation-mode CORDIC, one stage per iteration, with a side payload.
// Depends on atrs_pkg.
`timescale 1ns / 1ps
module atrs_cordic import atrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  atrs_in_t             item_i,
  output logic                 valid_o,
  output atrs_in_t             item_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  logic                 vld_q  [CORDIC_STAGES+1];
  logic                 flip_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] x_q    [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q    [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q    [CORDIC_STAGES+1];
  atrs_in_t             item_q [CORDIC_STAGES+1];

  logic                 flip_d;
  logic signed [ZW-1:0] z_d;

  // Fold the left half plane onto the right: flip the top angle bit and negate after
  always_comb begin
    flip_d = item_i.angle[15] ^ item_i.angle[14];
    z_d = ZW'($signed({item_i.angle[15] ^ flip_d, item_i.angle[14:0], 16'h0000}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q[0] <= flip_d;
    x_q[0]    <= GAIN_Q30;
    y_q[0]    <= '0;
    z_q[0]    <= z_d;
    item_q[0] <= item_i;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 pos;

    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign pos = !z_q[i][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      item_q[i+1] <= item_q[i];
      if (pos) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - atan_lut(i);
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + atan_lut(i);
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES];
  assign item_o  = item_q[CORDIC_STAGES];
  assign cos_o   = flip_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
  assign sin_o   = flip_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];

endmodule

/* rtl/atrs_matrix.sv */
// Five-stage matrix back end: scale products, rounding, origin products,
// translation sums and saturated shift. Depends on atrs_pkg.
`timescale 1ns / 1ps
module atrs_matrix import atrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  atrs_in_t             item_i,
  input  logic signed [CW-1:0] cos_i,
  input  logic signed [CW-1:0] sin_i,
  output logic                 valid_o,
  output atrs_out_t            result_o
);

  localparam int PW = CW + 16;
  localparam logic signed [PW:0] RndM = (PW+1)'(64'sd2097152);
  localparam logic signed [64:0] RndT = 65'sd32768;

  logic [4:0] vld_q;
  atrs_in_t   item_a_q, item_b_q, item_c_q, item_d_q;

  // Stage A: rotation times scale
  logic signed [PW-1:0] p00_q, p01_q, p10_q, p11_q;
  // Stage B: rounded linear terms
  logic signed [31:0]   m00_q, m01_q, m10_q, m11_q;
  logic signed [PW:0]   r00, r01, r10, r11;
  // Stage C: linear terms times origin
  logic signed [31:0]   c00_q, c01_q, c10_q, c11_q;
  logic signed [63:0]   q00_q, q01_q, q10_q, q11_q;
  // Stage D: rounded translations
  logic signed [31:0]   d00_q, d01_q, d10_q, d11_q;
  logic signed [64:0]   sum_x, sum_y;
  logic signed [48:0]   tx_q, ty_q;
  logic signed [49:0]   dif_x, dif_y;
  atrs_out_t            res_q;

  always_comb begin
    r00 = ((PW+1)'(p00_q) + RndM) >>> 22;
    r01 = ((PW+1)'(p01_q) + RndM) >>> 22;
    r10 = ((PW+1)'(p10_q) + RndM) >>> 22;
    r11 = (-(PW+1)'(p11_q) + RndM) >>> 22;
    sum_x = (65'(q00_q) + 65'(q01_q) + RndT) >>> 16;
    sum_y = (65'(q10_q) + 65'(q11_q) + RndT) >>> 16;
    dif_x = 50'(item_d_q.pos_x) - 50'(tx_q);
    dif_y = -50'(item_d_q.pos_y) - 50'(ty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    item_a_q <= item_i;
    p00_q    <= cos_i * PW'(item_i.scale_x);
    p01_q    <= sin_i * PW'(item_i.scale_y);
    p10_q    <= sin_i * PW'(item_i.scale_x);
    p11_q    <= cos_i * PW'(item_i.scale_y);

    item_b_q <= item_a_q;
    m00_q    <= r00[31:0];
    m01_q    <= r01[31:0];
    m10_q    <= r10[31:0];
    m11_q    <= r11[31:0];

    item_c_q <= item_b_q;
    c00_q    <= m00_q;
    c01_q    <= m01_q;
    c10_q    <= m10_q;
    c11_q    <= m11_q;
    q00_q    <= 64'(m00_q) * 64'(item_b_q.origin_x);
    q01_q    <= 64'(m01_q) * 64'(item_b_q.origin_y);
    q10_q    <= 64'(m10_q) * 64'(item_b_q.origin_x);
    q11_q    <= 64'(m11_q) * 64'(item_b_q.origin_y);

    item_d_q <= item_c_q;
    d00_q    <= c00_q;
    d01_q    <= c01_q;
    d10_q    <= c10_q;
    d11_q    <= c11_q;
    tx_q     <= sum_x[48:0];
    ty_q     <= sum_y[48:0];

    res_q.m00     <= d00_q;
    res_q.m01     <= d01_q;
    res_q.m10     <= d10_q;
    res_q.m11     <= d11_q;
    res_q.shift_x <= sat32(dif_x);
    res_q.shift_y <= sat32(dif_y);
  end

  assign valid_o  = vld_q[4];
  assign result_o = res_q;

endmodule

/* rtl/affine_trs_matrix_builder.sv */
// Top level of the affine TRS matrix builder: CORDIC front end and matrix back end.
// Depends on atrs_pkg, atrs_cordic and atrs_matrix.
`timescale 1ns / 1ps
// Builds one 2x3 sprite matrix M = T(px,-py) * R(angle) * S(sx,-sy) * T(-ox,-oy)
// per transaction. A transaction is taken on every cycle with start high; busy
// stays low, since the pipeline never holds. Each result appears on result_o for
// exactly one cycle with result_valid_o high; between its start and the result lie
// one input register, one register per CORDIC iteration and five matrix stages.
// The receiver must take every result when it is shown; results come out in the order
// the transactions went in.
module affine_trs_matrix_builder import atrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  atrs_in_t  in_i,
  output logic      result_valid_o,
  output atrs_out_t result_o
);

  logic                 cor_valid;
  atrs_in_t             cor_item;
  logic signed [CW-1:0] cor_cos, cor_sin;

  assign busy = 1'b0;

  atrs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (in_i),
    .valid_o (cor_valid),
    .item_o  (cor_item),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  atrs_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cor_valid),
    .item_i   (cor_item),
    .cos_i    (cor_cos),
    .sin_i    (cor_sin),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

/* rtl/atrs_checker.sv */
// Port-level checks for the affine TRS matrix builder, bound to the top level.
// Depends on atrs_pkg.
`timescale 1ns / 1ps
module atrs_checker import atrs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input atrs_in_t  in_i,
  input logic      result_valid_o,
  input atrs_out_t result_o
);

  logic acc;
  assign acc = start && !busy && rst_ni;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(acc, LATENCY))
    else $error("result strobe does not match accepted transaction");

  a_zero_sx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(in_i.scale_x, LATENCY) == 16'sd0
    |-> result_o.m00 == 32'sd0 && result_o.m10 == 32'sd0)
    else $error("zero horizontal scale gave nonzero terms");

  a_zero_sy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(in_i.scale_y, LATENCY) == 16'sd0
    |-> result_o.m01 == 32'sd0 && result_o.m11 == 32'sd0)
    else $error("zero vertical scale gave nonzero terms");

  a_zero_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(in_i.scale_x, LATENCY) == 16'sd0
    && $past(in_i.scale_y, LATENCY) == 16'sd0
    |-> result_o.shift_x == $past(in_i.pos_x, LATENCY))
    else $error("zero scale shift differs from position");

endmodule

bind affine_trs_matrix_builder atrs_checker u_atrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

/* test/atrs_checker.sv */
// Checker for the affine TRS matrix builder: predicts each matrix and compares results.
// Depends on atrs_pkg; instantiated beside the block by tb_affine_trs_matrix_builder.
`timescale 1ns / 1ps
module atrs_scoreboard import atrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  atrs_in_t  in_i,
  input  logic      result_valid_o,
  input  atrs_out_t result_o,
  output int        fail_count,
  output int        pending_count
);

  atrs_out_t matrix_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tab[i];
  endfunction

  function automatic atrs_out_t build_matrix(atrs_in_t it);
    atrs_out_t r;
    logic [31:0] th;
    bit flip;
    longint x, y, z, dx, dy, sx, sy, ox, oy, m00, m01, m10, m11, tx, ty;
    th = {it.angle, 16'h0};
    flip = 0;
    if (th >= 32'h4000_0000 && th < 32'hC000_0000) begin
      th = th - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(th));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sx = it.scale_x;
    sy = it.scale_y;
    ox = it.origin_x;
    oy = it.origin_y;
    m00 = floor_shr(x * sx + (1 << 21), 22);
    m01 = floor_shr(y * sy + (1 << 21), 22);
    m10 = floor_shr(y * sx + (1 << 21), 22);
    m11 = floor_shr(-(x * sy) + (1 << 21), 22);
    tx = floor_shr(m00 * ox + m01 * oy + (1 << 15), 16);
    ty = floor_shr(m10 * ox + m11 * oy + (1 << 15), 16);
    r.m00 = m00[31:0];
    r.m01 = m01[31:0];
    r.m10 = m10[31:0];
    r.m11 = m11[31:0];
    r.shift_x = 32'(clamp32(longint'(it.pos_x) - tx));
    r.shift_y = 32'(clamp32(-longint'(it.pos_y) - ty));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    atrs_out_t want;
    if (!rst_ni) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (start && !busy) matrix_q.push_back(build_matrix(in_i));
      if (result_valid_o) begin
        if (matrix_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", result_o);
          fail_count <= fail_count + 1;
        end else begin
          want = matrix_q.pop_front();
          if (want !== result_o) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", want, result_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= matrix_q.size();
    end
  end

endmodule

/* test/tb_affine_trs_matrix_builder.sv */
// Top of the affine TRS matrix builder testbench: clock, reset, stimulus, verdict.
// Depends on atrs_pkg, affine_trs_matrix_builder and atrs_scoreboard.
`timescale 1ns / 1ps
module tb_affine_trs_matrix_builder;
  import atrs_pkg::*;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      start = 0;
  logic      busy;
  atrs_in_t  in_i = '0;
  logic      result_valid_o;
  atrs_out_t result_o;
  int        fail_count, pending_count;

  affine_trs_matrix_builder dut (.*);
  atrs_scoreboard chk (.*);

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one transaction and hold until it is taken.
  task automatic send_item(atrs_in_t it);
    in_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause_start(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  initial begin
    atrs_in_t it;
    int left, burst;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: quadrant edges, extreme values, zero and negative scales
    for (int k = 0; k < 24; k++) begin
      it.angle = 16'(k * 16'h1000 + (k % 3) - 1);
      it.pos_x = (k & 1) ? 32'h7fff_ffff : 32'h8000_0000;
      it.pos_y = (k & 2) ? 32'h7fff_ffff : 32'h8000_0000;
      it.origin_x = (k & 4) ? 32'h7fff_ffff : 32'h8000_0000;
      it.origin_y = (k & 8) ? 32'h8000_0000 : 32'h7fff_ffff;
      it.scale_x = (k % 3 == 0) ? 16'h0000 : ((k & 1) ? 16'h7fff : 16'h8000);
      it.scale_y = (k % 4 == 0) ? 16'h0100 : ((k & 2) ? 16'h8000 : 16'h7fff);
      send_item(it);
    end
    left = 1050;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && left > 0; b++, left--) begin
        it.pos_x = pick32();
        it.pos_y = pick32();
        it.origin_x = pick32();
        it.origin_y = pick32();
        it.scale_x = pick16();
        it.scale_y = pick16();
        it.angle = 16'($urandom);
        send_item(it);
      end
      if ($urandom_range(0, 3) != 0) pause_start($urandom_range(1, 30));
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/atrs_pkg.sv
rtl/atrs_cordic.sv
rtl/atrs_matrix.sv
rtl/affine_trs_matrix_builder.sv
rtl/atrs_checker.sv
test/atrs_checker.sv
test/tb_affine_trs_matrix_builder.sv
